### sv/asp_pkg.sv
// ---------------------------------------------------------------------------
// asp_pkg: shared constants for the setpoint-to-attitude pipeline
// Angle formats, CORDIC constants and the arctangent step table.
// ---------------------------------------------------------------------------
package asp_pkg;

    localparam int ANG_W             = 35;  // signed radians, 30 fraction bits
    localparam int CS_W              = 34;  // sin/cos datapath width
    localparam int MAX_STAGES        = 24;
    localparam int DEF_CORDIC_STAGES = 16;
    localparam int DEF_FIELD_WIDTH   = 16;
    localparam int GRAV_W            = 15;
    localparam int KINV_W            = 30;

    localparam logic [GRAV_W-1:0]       GRAV_RESET  = 15'd2511;
    localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic [KINV_W-1:0]       KINV_Q30    = 30'd652032874;

    // atan(2^-i) in Q30, truncated
    function automatic logic signed [ANG_W-1:0] atan_q30(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:       v = 35'sd843314856;
            1:       v = 35'sd497837829;
            2:       v = 35'sd263043836;
            3:       v = 35'sd133525158;
            4:       v = 35'sd67021686;
            5:       v = 35'sd33543515;
            6:       v = 35'sd16775850;
            7:       v = 35'sd8388437;
            8:       v = 35'sd4194282;
            9:       v = 35'sd2097149;
            10:      v = 35'sd1048575;
            11:      v = 35'sd524287;
            12:      v = 35'sd262143;
            13:      v = 35'sd131071;
            14:      v = 35'sd65535;
            15:      v = 35'sd32767;
            16:      v = 35'sd16383;
            17:      v = 35'sd8191;
            18:      v = 35'sd4095;
            19:      v = 35'sd2047;
            20:      v = 35'sd1023;
            21:      v = 35'sd511;
            22:      v = 35'sd255;
            23:      v = 35'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### sv/accel_setpoint_to_attitude.sv
// ---------------------------------------------------------------------------
// accel_setpoint_to_attitude: acceleration setpoint to attitude setpoint
// Gravity add, yaw de-rotation, pitch/roll by CORDIC, fully pipelined.
// ---------------------------------------------------------------------------
// Usage:
//  - Slave stream (s_axis_*) takes one word per setpoint: acc_x, acc_y,
//    acc_z (Q8.8 m/s^2) and yaw_in (Q2.13 rad), packed from bit 0 up.
//  - Master stream (m_axis_*) returns one word per setpoint: pitch_out,
//    roll_out, yaw_out in tdata and status in tuser (1 = zero vector,
//    angles forced to zero, yaw still passed through).
//  - i_cfg_we/i_cfg_data load the gravity offset; change it only while idle.
//  - Throughput: one word per cycle sustained while m_axis_tready stays
//    high. Every pipeline register advances on a single enable, so there
//    is no combinational path from m_axis_tready to s_axis_tready.
//  - Pipeline: 3*CORDIC_STAGES + 7 register stages (55 at 16 stages): input
//    stage, sin/cos chain, two product stages, vector setup, pitch chain,
//    two scaling stages, roll chain, output register. The three CORDIC
//    chains make up most of these stages.
//  - Stall: the output register holds while m_axis_tready is low; one skid
//    register catches the word already in flight, and only when that skid
//    is full does s_axis_tready drop, freezing the whole pipe.
//  - Reset (i_rst_n low, synchronous) empties the pipe and skid, and loads
//    the gravity offset with 9.81 m/s^2 (2511 in Q8.8).
// ---------------------------------------------------------------------------
module accel_setpoint_to_attitude #(
    parameter int CORDIC_STAGES = asp_pkg::DEF_CORDIC_STAGES,
    parameter int FIELD_WIDTH   = asp_pkg::DEF_FIELD_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // config: gravity offset, Q7.8 unsigned
    input  logic                                  i_cfg_we,
    input  logic [asp_pkg::GRAV_W-1:0]            i_cfg_data,
    // tdata: acc_x, acc_y, acc_z, yaw_in (low to high), zero padded
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((4*FIELD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // tdata: pitch_out, roll_out, yaw_out (low to high), zero padded
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((3*FIELD_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    // tuser: status
    output logic                                  m_axis_tuser
);
    import asp_pkg::*;

    localparam int FW    = FIELD_WIDTH;
    localparam int N     = CORDIC_STAGES;
    localparam int AW    = ANG_W;
    localparam int CW    = CS_W;
    localparam int ZW    = ((FW > 16) ? FW : 16) + 1;     // z plus gravity
    localparam int TZW   = ZW + 16;                        // z scaled by 2^16
    localparam int TW    = FW + 18;                        // de-rotated x/y
    localparam int PW    = CW + FW + 1;                    // product sum
    localparam int VW    = ((TZW > TW) ? TZW : TW) + 3;    // vectoring datapath
    localparam int SH    = 33 - FW;                        // Q30 to field
    localparam int OUT_W = ((3*FW+7)/8)*8;
    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (SH - 1);
    localparam logic signed [AW-1:0] LIM  = (HALF_PI_Q30 + HALF) >>> SH;

    // sideband layouts
    localparam int SA_W = 3*FW + ZW + 3;   // x, y, z, neg, zero, tzz, yaw
    localparam int SB_W = TW + 4 + FW;     // ty, zero, tzz, txp, txn, yaw
    localparam int SC_W = AW + 1 + FW;     // pitch, zero, yaw

    logic r_out_v, r_skid_v;
    logic en;
    assign en            = ~r_skid_v;
    assign s_axis_tready = en;

    // ---------------- config ----------------
    logic [GRAV_W-1:0] r_gravity;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= GRAV_RESET;
        end else if (i_cfg_we) begin
            r_gravity <= i_cfg_data;
        end
    end

    // ---------------- stage 0: gravity, yaw range reduction ----------------
    logic signed [FW-1:0] in_x, in_y, in_z, in_yaw;
    logic signed [ZW-1:0] z_sum;
    logic signed [AW-1:0] yaw_q, yaw_r;
    logic                 yaw_neg;

    assign in_x   = s_axis_tdata[FW-1:0];
    assign in_y   = s_axis_tdata[2*FW-1:FW];
    assign in_z   = s_axis_tdata[3*FW-1:2*FW];
    assign in_yaw = s_axis_tdata[4*FW-1:3*FW];
    assign z_sum  = ZW'(in_z) + ZW'(r_gravity);
    assign yaw_q  = {{2{in_yaw[FW-1]}}, in_yaw, {SH{1'b0}}};

    always_comb begin
        yaw_r   = yaw_q;
        yaw_neg = 1'b0;
        if (yaw_q > HALF_PI_Q30) begin
            yaw_r   = yaw_q - PI_Q30;
            yaw_neg = 1'b1;
        end else if (yaw_q < -HALF_PI_Q30) begin
            yaw_r   = yaw_q + PI_Q30;
            yaw_neg = 1'b1;
        end
    end

    logic                 r0_v;
    logic signed [AW-1:0] r0_ang;
    logic [SA_W-1:0]      r0_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (en) begin
            r0_v <= s_axis_tvalid;
        end
        if (en) begin
            r0_ang  <= yaw_r;
            r0_side <= {in_yaw, (z_sum == '0),
                        (in_x == '0) && (in_y == '0) && (z_sum == '0),
                        yaw_neg, z_sum, in_y, in_x};
        end
    end

    // ---------------- chain A: sin/cos of yaw ----------------
    logic                 a_v;
    logic signed [CW-1:0] a_c, a_s;
    logic [SA_W-1:0]      a_side;

    asp_cordic_chain #(
        .N(N), .DW(CW), .AW(AW), .SW(SA_W), .ROTATE(1'b1)
    ) u_chain_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r0_v), .i_x(CW'(KINV_Q30)), .i_y('0), .i_z(r0_ang),
        .i_side(r0_side),
        .o_valid(a_v), .o_x(a_c), .o_y(a_s), .o_z(), .o_side(a_side)
    );

    logic signed [FW-1:0] a_x, a_y;
    assign a_x = a_side[FW-1:0];
    assign a_y = a_side[2*FW-1:FW];

    // ---------------- stage 1: products ----------------
    logic                    r1_v;
    logic signed [CW+FW-1:0] r1_cx, r1_sy, r1_cy, r1_sx;
    logic signed [ZW-1:0]    r1_z;
    logic                    r1_neg, r1_zero, r1_tzz;
    logic [FW-1:0]           r1_yaw;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= a_v;
        end
        if (en) begin
            r1_cx   <= (CW+FW)'(a_c) * (CW+FW)'(a_x);
            r1_sy   <= (CW+FW)'(a_s) * (CW+FW)'(a_y);
            r1_cy   <= (CW+FW)'(a_c) * (CW+FW)'(a_y);
            r1_sx   <= (CW+FW)'(a_s) * (CW+FW)'(a_x);
            r1_z    <= a_side[2*FW+ZW-1:2*FW];
            r1_neg  <= a_side[2*FW+ZW];
            r1_zero <= a_side[2*FW+ZW+1];
            r1_tzz  <= a_side[2*FW+ZW+2];
            r1_yaw  <= a_side[SA_W-1:SA_W-FW];
        end
    end

    // ---------------- stage 2: sums, undo pi shift ----------------
    logic signed [PW-1:0] sum_x, sum_y, fx, fy;
    assign sum_x = PW'(r1_cx) + PW'(r1_sy);
    assign sum_y = PW'(r1_cy) - PW'(r1_sx);
    assign fx    = r1_neg ? -sum_x : sum_x;
    assign fy    = r1_neg ? -sum_y : sum_y;

    logic                  r2_v;
    logic signed [TW-1:0]  r2_tx, r2_ty;
    logic signed [TZW-1:0] r2_tz;
    logic                  r2_zero, r2_tzz;
    logic [FW-1:0]         r2_yaw;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
        if (en) begin
            r2_tx   <= TW'(fx >>> 14);
            r2_ty   <= TW'(fy >>> 14);
            r2_tz   <= {r1_z, 16'b0};
            r2_zero <= r1_zero;
            r2_tzz  <= r1_tzz;
            r2_yaw  <= r1_yaw;
        end
    end

    // ---------------- stage 3: fold into right half-plane ----------------
    logic                 r3_v;
    logic signed [VW-1:0] r3_x, r3_y;
    logic [SB_W-1:0]      r3_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
        if (en) begin
            r3_x    <= r2_tz[TZW-1] ? -VW'(r2_tz) : VW'(r2_tz);
            r3_y    <= r2_tz[TZW-1] ? -VW'(r2_tx) : VW'(r2_tx);
            r3_side <= {r2_yaw, r2_tx[TW-1],
                        ~r2_tx[TW-1] && (r2_tx != '0),
                        r2_tzz, r2_zero, r2_ty};
        end
    end

    // ---------------- chain B: pitch and magnitude ----------------
    logic                 b_v;
    logic signed [VW-1:0] b_m;
    logic signed [AW-1:0] b_ang;
    logic [SB_W-1:0]      b_side;

    asp_cordic_chain #(
        .N(N), .DW(VW), .AW(AW), .SW(SB_W), .ROTATE(1'b0)
    ) u_chain_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r3_v), .i_x(r3_x), .i_y(r3_y), .i_z('0),
        .i_side(r3_side),
        .o_valid(b_v), .o_x(b_m), .o_y(), .o_z(b_ang), .o_side(b_side)
    );

    logic signed [TW-1:0] b_ty;
    logic                 b_zero, b_tzz, b_txp, b_txn;
    logic [VW-1:0]        m_clip;
    logic signed [AW-1:0] pitch_sel;
    assign b_ty   = b_side[TW-1:0];
    assign b_zero = b_side[TW];
    assign b_tzz  = b_side[TW+1];
    assign b_txp  = b_side[TW+2];
    assign b_txn  = b_side[TW+3];
    assign m_clip = b_m[VW-1] ? '0 : b_m;

    always_comb begin
        pitch_sel = b_ang;
        if (b_tzz) begin
            if (b_txp) begin
                pitch_sel = HALF_PI_Q30;
            end else if (b_txn) begin
                pitch_sel = -HALF_PI_Q30;
            end else begin
                pitch_sel = '0;
            end
        end
    end

    // ---------------- stage 4: gain correction products ----------------
    logic                 r4_v;
    logic [VW+9:0]        r4_hik;
    logic [49:0]          r4_lok;
    logic signed [VW-1:0] r4_nty;
    logic signed [AW-1:0] r4_pitch;
    logic                 r4_zero;
    logic [FW-1:0]        r4_yaw;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= b_v;
        end
        if (en) begin
            r4_hik   <= (VW+10)'(m_clip[VW-1:20]) * (VW+10)'(KINV_Q30);
            r4_lok   <= 50'(m_clip[19:0]) * 50'(KINV_Q30);
            r4_nty   <= -VW'(b_ty);
            r4_pitch <= pitch_sel;
            r4_zero  <= b_zero;
            r4_yaw   <= b_side[SB_W-1:SB_W-FW];
        end
    end

    // ---------------- stage 5: scaled magnitude ----------------
    logic                 r5_v;
    logic signed [VW-1:0] r5_x, r5_y;
    logic [SC_W-1:0]      r5_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= r4_v;
        end
        if (en) begin
            r5_x    <= VW'(r4_hik >> 10) + VW'(r4_lok >> 30);
            r5_y    <= r4_nty;
            r5_side <= {r4_yaw, r4_zero, r4_pitch};
        end
    end

    // ---------------- chain C: roll ----------------
    logic                 c_v;
    logic signed [AW-1:0] c_roll;
    logic [SC_W-1:0]      c_side;

    asp_cordic_chain #(
        .N(N), .DW(VW), .AW(AW), .SW(SC_W), .ROTATE(1'b0)
    ) u_chain_c (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r5_v), .i_x(r5_x), .i_y(r5_y), .i_z('0),
        .i_side(r5_side),
        .o_valid(c_v), .o_x(), .o_y(), .o_z(c_roll), .o_side(c_side)
    );

    // ---------------- output rounding ----------------
    // round half up to the field format, clamp to +-pi/2
    function automatic logic [FW-1:0] to_field(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] r;
        r = (a + HALF) >>> SH;
        if (r > LIM) begin
            r = LIM;
        end else if (r < -LIM) begin
            r = -LIM;
        end
        return r[FW-1:0];
    endfunction

    logic             c_zero;
    logic [FW-1:0]    p_pitch, p_roll;
    logic [OUT_W-1:0] p_data;
    logic             p_fire;
    assign c_zero  = c_side[AW];
    assign p_pitch = c_zero ? '0 : to_field(c_side[AW-1:0]);
    assign p_roll  = c_zero ? '0 : to_field(c_roll);
    assign p_data  = OUT_W'({c_side[SC_W-1:SC_W-FW], p_roll, p_pitch});
    assign p_fire  = en && c_v;

    // ---------------- output register and skid ----------------
    logic [OUT_W-1:0] r_out_data, r_skid_data;
    logic             r_out_user, r_skid_user;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || m_axis_tready) begin
            if (r_skid_v) begin
                r_out_v    <= 1'b1;
                r_out_data <= r_skid_data;
                r_out_user <= r_skid_user;
                r_skid_v   <= 1'b0;
            end else begin
                r_out_v    <= p_fire;
                r_out_data <= p_data;
                r_out_user <= c_zero;
            end
        end else if (p_fire) begin
            r_skid_v    <= 1'b1;
            r_skid_data <= p_data;
            r_skid_user <= c_zero;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

### sv/asp_cordic_cell.sv
// ---------------------------------------------------------------------------
// asp_cordic_cell: one registered CORDIC micro-rotation
// Rotation mode steers on the angle sign, vectoring mode on the y sign.
// ---------------------------------------------------------------------------
module asp_cordic_cell #(
    parameter int STAGE  = 0,
    parameter int DW     = 34,
    parameter int AW     = 35,
    parameter int SW     = 1,
    parameter bit ROTATE = 1'b1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [DW-1:0] i_x,
    input  logic signed [DW-1:0] i_y,
    input  logic signed [AW-1:0] i_z,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output logic signed [DW-1:0] o_x,
    output logic signed [DW-1:0] o_y,
    output logic signed [AW-1:0] o_z,
    output logic [SW-1:0]        o_side
);
    import asp_pkg::*;

    localparam logic signed [AW-1:0] ATAN = AW'(atan_q30(STAGE));

    logic                 sigma_pos;
    logic signed [DW-1:0] x_sh, y_sh, n_x, n_y;
    logic signed [AW-1:0] n_z;
    logic                 r_valid;
    logic signed [DW-1:0] r_x, r_y;
    logic signed [AW-1:0] r_z;
    logic [SW-1:0]        r_side;

    assign sigma_pos = ROTATE ? ~i_z[AW-1] : i_y[DW-1];
    assign x_sh      = i_x >>> STAGE;
    assign y_sh      = i_y >>> STAGE;

    always_comb begin
        if (sigma_pos) begin
            n_x = i_x - y_sh;
            n_y = i_y + x_sh;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + y_sh;
            n_y = i_y - x_sh;
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

### sv/asp_cordic_chain.sv
// ---------------------------------------------------------------------------
// asp_cordic_chain: row of CORDIC cells, one micro-rotation per cell
// Sideband bits ride along so each word leaves with its own context.
// ---------------------------------------------------------------------------
module asp_cordic_chain #(
    parameter int N      = 16,
    parameter int DW     = 34,
    parameter int AW     = 35,
    parameter int SW     = 1,
    parameter bit ROTATE = 1'b1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [DW-1:0] i_x,
    input  logic signed [DW-1:0] i_y,
    input  logic signed [AW-1:0] i_z,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output logic signed [DW-1:0] o_x,
    output logic signed [DW-1:0] o_y,
    output logic signed [AW-1:0] o_z,
    output logic [SW-1:0]        o_side
);
    logic                 v_w    [N+1];
    logic signed [DW-1:0] x_w    [N+1];
    logic signed [DW-1:0] y_w    [N+1];
    logic signed [AW-1:0] z_w    [N+1];
    logic [SW-1:0]        side_w [N+1];

    assign v_w[0]    = i_valid;
    assign x_w[0]    = i_x;
    assign y_w[0]    = i_y;
    assign z_w[0]    = i_z;
    assign side_w[0] = i_side;

    for (genvar g = 0; g < N; g++) begin : g_cell
        asp_cordic_cell #(
            .STAGE(g), .DW(DW), .AW(AW), .SW(SW), .ROTATE(ROTATE)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (i_en),
            .i_valid(v_w[g]),
            .i_x    (x_w[g]),
            .i_y    (y_w[g]),
            .i_z    (z_w[g]),
            .i_side (side_w[g]),
            .o_valid(v_w[g+1]),
            .o_x    (x_w[g+1]),
            .o_y    (y_w[g+1]),
            .o_z    (z_w[g+1]),
            .o_side (side_w[g+1])
        );
    end

    assign o_valid = v_w[N];
    assign o_x     = x_w[N];
    assign o_y     = y_w[N];
    assign o_z     = z_w[N];
    assign o_side  = side_w[N];

endmodule

### sv/asp_checker.sv
// ---------------------------------------------------------------------------
// asp_checker: port-level checks for accel_setpoint_to_attitude
// Reset, stall, backpressure and zero-vector result checks.
// ---------------------------------------------------------------------------
module asp_checker #(
    parameter int FIELD_WIDTH = asp_pkg::DEF_FIELD_WIDTH
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [((3*FIELD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input logic                               m_axis_tuser
);
    localparam int FW = FIELD_WIDTH;

    // reset empties the pipe and reopens the input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output valid or input blocked after reset");

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output word changed");

    // input only blocks while a result is waiting at the output
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input blocked with empty output");

    // zero vector forces both angles to zero
    a_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[FW-1:0] == '0) && (m_axis_tdata[2*FW-1:FW] == '0))
        else $error("zero-vector word carries nonzero angles");

endmodule

bind accel_setpoint_to_attitude asp_checker #(.FIELD_WIDTH(FIELD_WIDTH)) u_asp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);

### verif/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for accel_setpoint_to_attitude
// Drives acceleration/yaw words through the slave stream under random gaps
// and output stalls. Each accepted word is predicted by a bit-exact attitude
// model, or by a directed row's typed result, and matched in order to the
// master stream. Gravity sweep: reset value, both extremes, 1, a random one.
// ---------------------------------------------------------------------------
module tb_top;
    import asp_pkg::*;

    localparam int FW      = DEF_FIELD_WIDTH;
    localparam int STAGES  = DEF_CORDIC_STAGES;
    localparam int LATENCY = 3*STAGES + 7;
    localparam int LIMIT   = 400000;
    localparam int N_RAND  = 1320;

    typedef struct packed {
        logic signed [FW-1:0] pitch;
        logic signed [FW-1:0] roll;
        logic signed [FW-1:0] yaw;
        logic                 status;
    } attitude_t;

    // directed row: inputs, plus expected result where it is obvious
    typedef struct {
        logic signed [FW-1:0] ax, ay, az, yaw;
        bit                   typed;
        attitude_t            want;
    } row_t;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic [GRAV_W-1:0]            i_cfg_data = '0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    // tdata: acc_x, acc_y, acc_z, yaw_in (low to high)
    logic [63:0]                  s_axis_tdata = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    // tdata: pitch_out, roll_out, yaw_out (low to high)
    logic [47:0]                  m_axis_tdata;
    // tuser: status
    logic                         m_axis_tuser;

    accel_setpoint_to_attitude u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // bench state
    longint    gravity = GRAV_RESET;
    attitude_t pending_att[$];
    int        mismatches = 0;
    int        words_in = 0, words_out = 0, zero_hits = 0;
    longint    cycles = 0;
    bit        send_idle = 1'b1, recv_idle = 1'b1;
    // typed expectation for the word being sent, updated at the rising edge
    bit        ovr_on = 1'b0;
    attitude_t ovr_att = '0;

    // atan(2^-i) in Q30, truncated
    longint atan_step[24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127};

    // rotation mode: cos/sin of a Q30 angle, with one pi fold
    function automatic void rot_sincos(input longint ang, output longint c, output longint s);
        longint x, y, z, nx, ny;
        bit     flip;
        x = longint'(KINV_Q30); y = 0; z = ang; flip = 0;
        if (z > longint'(HALF_PI_Q30)) begin
            z -= longint'(PI_Q30); flip = 1;
        end else if (z < -longint'(HALF_PI_Q30)) begin
            z += longint'(PI_Q30); flip = 1;
        end
        for (int i = 0; i < STAGES; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_step[i];
            end else begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += atan_step[i];
            end
            x = nx; y = ny;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // vectoring mode: angle of (x, y), x >= 0, plus raw magnitude
    function automatic longint vec_angle(input longint x0, input longint y0,
                                         output longint mag);
        longint x, y, z, nx, ny;
        x = x0; y = y0; z = 0;
        for (int i = 0; i < STAGES; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += atan_step[i];
            end else begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_step[i];
            end
            x = nx; y = ny;
        end
        mag = x;
        return z;
    endfunction

    function automatic longint gain_fix(input longint m);
        longint hi, lo;
        if (m < 0) m = 0;
        hi = m >>> 20;
        lo = m & 64'hFFFFF;
        return ((hi * longint'(KINV_Q30)) >>> 10) + ((lo * longint'(KINV_Q30)) >>> 30);
    endfunction

    // Q30 angle to output field: round half up, clamp to +-pi/2
    function automatic logic signed [FW-1:0] to_angle_field(input longint a);
        longint half, lim, r;
        half = longint'(1) << (32 - FW);
        lim  = (longint'(HALF_PI_Q30) + half) >>> (33 - FW);
        r    = (a + half) >>> (33 - FW);
        if (r > lim)  r = lim;
        if (r < -lim) r = -lim;
        return r[FW-1:0];
    endfunction

    function automatic attitude_t predict_attitude(input logic [63:0] w, input longint grav);
        attitude_t res;
        longint x, y, z, yaw, c, s, tx, ty, tz, pitch, roll, m, unused;
        x   = longint'($signed(w[15:0]));
        y   = longint'($signed(w[31:16]));
        z   = longint'($signed(w[47:32])) + grav;
        yaw = longint'($signed(w[63:48])) * (longint'(1) << (33 - FW));
        res.yaw = w[63:48];
        if (x == 0 && y == 0 && z == 0) begin
            res.pitch = '0; res.roll = '0; res.status = 1'b1;
            return res;
        end
        rot_sincos(yaw, c, s);
        tx = (c * x + s * y) >>> 14;
        ty = (c * y - s * x) >>> 14;
        tz = z * 65536;
        pitch = vec_angle(tz < 0 ? -tz : tz, tz < 0 ? -tx : tx, m);
        // thrust lying flat: pitch is +-pi/2 by the sign of tx, or zero if tx is zero
        if (tz == 0)
            pitch = tx > 0 ? longint'(HALF_PI_Q30) : (tx < 0 ? -longint'(HALF_PI_Q30) : 0);
        roll = vec_angle(gain_fix(m), -ty, unused);
        res.pitch  = to_angle_field(pitch);
        res.roll   = to_angle_field(roll);
        res.status = 1'b0;
        return res;
    endfunction

    // prediction at input accept, checking at output accept
    always @(posedge i_clk) begin
        attitude_t want, got;
        cycles++;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                pending_att.push_back(ovr_on ? ovr_att
                                             : predict_attitude(s_axis_tdata, gravity));
                words_in++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                       m_axis_tuser};
                words_out++;
                if (got.status) zero_hits++;
                if (pending_att.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected word %h status %b", m_axis_tdata,
                                 m_axis_tuser);
                end else begin
                    want = pending_att.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: word %0d pitch %0d/%0d roll %0d/%0d yaw %0d/%0d st %b/%b",
                                     words_out, want.pitch, got.pitch, want.roll, got.roll,
                                     want.yaw, got.yaw, want.status, got.status);
                    end
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stall before each word, or none in no-idle phases
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            n = recv_idle ? $urandom_range(0, 9) : 0;
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // one word: optional gap, then hold until accepted
    task automatic send_word(input logic signed [FW-1:0] ax, ay, az, yaw);
        int n;
        n = send_idle ? $urandom_range(0, 9) : 0;
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {yaw, az, ay, ax};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // drop valid, wait for the pipe to drain, then settle
    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_att.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic load_gravity(input logic [GRAV_W-1:0] g);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= g;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        gravity     = g;
        @(posedge i_clk);
    endtask

    // random word, biased toward the corners of the behavior
    task automatic send_random();
        logic signed [FW-1:0] ax, ay, az, yaw;
        ax = FW'($urandom); ay = FW'($urandom); az = FW'($urandom); yaw = FW'($urandom);
        case ($urandom_range(0, 9))
            0: begin  // zero thrust vector
                ax = '0; ay = '0; az = FW'(-gravity);
            end
            1: az = FW'(-gravity);  // thrust in the horizontal plane
            2: begin  // hover-ish small commands
                ax = FW'($signed($urandom_range(0, 1023)) - 512);
                ay = FW'($signed($urandom_range(0, 1023)) - 512);
                az = FW'($signed($urandom_range(0, 1023)) - 512);
            end
            3: yaw = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            4: begin  // y zeroed, x kept or zeroed
                ay = '0; ax = $urandom_range(0, 1) ? ax : '0;
            end
            default: ;
        endcase
        send_word(ax, ay, az, yaw);
    endtask

    row_t dir_rows[$];

    initial begin
        row_t r;
        attitude_t zero_att, flat_att;
        logic [GRAV_W-1:0] grav_set[5];
        longint lim_f;

        lim_f = (longint'(HALF_PI_Q30) + (longint'(1) << (32 - FW))) >>> (33 - FW);
        zero_att = '{pitch: 0, roll: 0, yaw: 0, status: 1'b1};

        // extremes of every field, reset gravity
        r = '{ax: 0, ay: 0, az: 0, yaw: 0, typed: 0, want: zero_att};   dir_rows.push_back(r);
        r = '{ax: 0, ay: 0, az: -2511, yaw: 0, typed: 1, want: zero_att};
        dir_rows.push_back(r);
        r.yaw = 16'sh7FFF; r.want.yaw = 16'sh7FFF;                       dir_rows.push_back(r);
        r.yaw = 16'sh8000; r.want.yaw = 16'sh8000;                       dir_rows.push_back(r);
        r = '{ax: 16'sh7FFF, ay: 0, az: -2511, yaw: 0, typed: 0, want: zero_att};
        dir_rows.push_back(r);  // flat thrust, +x
        r.ax = 16'sh8000;                                                 dir_rows.push_back(r);
        r.ax = 1;                                                         dir_rows.push_back(r);
        r.ax = -1;                                                        dir_rows.push_back(r);
        r.ax = 0; r.ay = 16'sh7FFF;                                       dir_rows.push_back(r);
        r.ay = 16'sh8000;                                                 dir_rows.push_back(r);
        r = '{ax: 16'sh7FFF, ay: 16'sh7FFF, az: 16'sh7FFF, yaw: 16'sh7FFF, typed: 0,
              want: zero_att};                                            dir_rows.push_back(r);
        r = '{ax: 16'sh8000, ay: 16'sh8000, az: 16'sh8000, yaw: 16'sh8000, typed: 0,
              want: zero_att};                                            dir_rows.push_back(r);
        r = '{ax: 0, ay: 0, az: 16'sh8000, yaw: 0, typed: 0, want: zero_att};
        dir_rows.push_back(r);  // thrust straight down
        r.az = 16'sh7FFF;                                                 dir_rows.push_back(r);
        r = '{ax: 256, ay: 256, az: 0, yaw: 12868, typed: 0, want: zero_att};
        dir_rows.push_back(r);  // yaw just around +pi/2
        r.yaw = 12869;                                                    dir_rows.push_back(r);
        r.yaw = -12869;                                                   dir_rows.push_back(r);
        r.yaw = 25736;                                                    dir_rows.push_back(r);
        r = '{ax: -700, ay: 300, az: -2000, yaw: -25736, typed: 0, want: zero_att};
        dir_rows.push_back(r);

        grav_set = '{15'd0, 15'h7FFF, 15'd2511, 15'd1, 15'(($urandom))};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows at reset gravity, no idling
        send_idle = 0; recv_idle = 0;
        foreach (dir_rows[k]) begin
            // typed rows replace the model's prediction with the obvious answer
            ovr_on  <= dir_rows[k].typed;
            ovr_att <= dir_rows[k].want;
            send_word(dir_rows[k].ax, dir_rows[k].ay, dir_rows[k].az, dir_rows[k].yaw);
        end
        ovr_on <= 1'b0;
        // flat +x thrust must clamp pitch to +pi/2
        drain_pipe();
        flat_att = predict_attitude({16'sd0, -16'sd2511, 16'sd0, 16'sh0100}, gravity);
        if (flat_att.pitch != lim_f[FW-1:0]) begin
            mismatches++;
            $display("ERROR: flat thrust pitch predicted %0d", flat_att.pitch);
        end
        send_word(16'sh0100, 0, -2511, 0);
        drain_pipe();

        // random phases across gravity settings and idle modes
        foreach (grav_set[p]) begin
            load_gravity(grav_set[p]);
            send_idle = (p % 3) != 1;
            recv_idle = (p % 3) != 2;
            for (int k = 0; k < N_RAND / 5; k++) begin
                send_random();
                if (k == 100) begin  // let the pipe empty mid-phase
                    s_axis_tvalid <= 1'b0;
                    @(posedge i_clk);
                    while (pending_att.size() != 0) @(posedge i_clk);
                end
            end
            drain_pipe();
        end

        $display("covered %0d words in, %0d out, %0d zero-vector results",
                 words_in, words_out, zero_hits);
        $display("gravity swept over 0, 32767, 2511, 1 and a random setting; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pending_att.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
sv/asp_pkg.sv
sv/asp_cordic_cell.sv
sv/asp_cordic_chain.sv
sv/accel_setpoint_to_attitude.sv
sv/asp_checker.sv
verif/tb_top.sv
